// File: design/scfd_pkg.sv
// shared types and constants of the serial command frame decoder
package scfd_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 20;
  // frame length field covers the whole supported range of frame store sizes
  localparam int unsigned LEN_W           = 5;
  // longest pattern plus payload window reaches byte 13
  localparam int unsigned SNAP_BYTES      = 14;
  localparam int unsigned Q_DEPTH         = 2;
  localparam int unsigned CMD_W           = 5;
  localparam int unsigned PAY_W           = 32;
  localparam int unsigned IN_TDATA_W      = 8;
  localparam int unsigned OUT_TDATA_W     = 40;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_A  = 8'h41;

  typedef enum logic [CMD_W-1:0] {
    CMD_UNKNOWN = 5'd0,
    CMD_AT      = 5'd1,
    CMD_AT_R    = 5'd2,
    CMD_AS      = 5'd3,
    CMD_AB      = 5'd4,
    CMD_AR      = 5'd5,
    CMD_AQ      = 5'd6,
    CMD_AX      = 5'd7,
    CMD_AY      = 5'd8,
    CMD_AA      = 5'd9,
    CMD_PRINT   = 5'd10,
    CMD_NOHEAT  = 5'd11,
    CMD_HF      = 5'd12,
    CMD_AME     = 5'd13,
    CMD_AMC     = 5'd14,
    CMD_AWR1    = 5'd15,
    CMD_AWR2    = 5'd16,
    CMD_AAGE    = 5'd17,
    CMD_ACAF    = 5'd18,
    CMD_AGYS    = 5'd19
  } cmd_t;

  // finished frame handed from the assembler to the matcher
  typedef struct packed {
    logic [LEN_W-1:0]                len;
    logic [SNAP_BYTES-1:0][7:0]      bytes;
  } frame_t;

endpackage

// File: design/serial_command_frame_decoder_unit.sv
// top level of the serial command frame decoder
// Usage:
//   in_*  : one received serial byte per request (in_tdata[7:0]).
//   out_* : one result per finished frame; out_tdata holds the command code
//           in bits [4:0] and the little-endian payload word in bits [36:5].
//   Bytes fill a frame store that wraps at FRAME_BYTES. A byte pair CR LF
//   closes a frame, which is matched by length and leading bytes against the
//   command table; unknown frames give command 0. A frame whose first byte
//   is not 'A' is dropped and the store restarts.
// Flow: the frame is written into the queue when the LF byte is accepted,
//   then is taken from the queue and matched into the output register that
//   drives out_tvalid; a stall on out_tready can hold it in the queue.
// Throughput: one byte per cycle while in_tready is high (it drops when the
//   frame queue is full); results leave at up to one per cycle.
// Reset: rst_n (synchronous, active low) empties the fill index, the frame
//   queue and the output register; the first byte after reset starts a frame.
// Stall: with out_tready low, the output register holds its result and up
//   to two more finished frames wait in the queue; in_tready drops only when
//   that queue is full, so bytes keep flowing while the receiver is busy.
module serial_command_frame_decoder_unit
  import scfd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [4:0] command, [36:5] payload, [39:37] zero
);

  logic   push;
  frame_t push_frame;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  frame_t head_frame;

  scfd_frame_asm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (push),
    .push_frame (push_frame),
    .q_full     (q_full)
  );

  scfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  scfd_cmd_match u_cmd_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_frame (head_frame),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: design/scfd_frame_asm.sv
// front end: frame store, fill index and cr lf frame end detection
module scfd_frame_asm
  import scfd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] rx_byte
  output logic                  push,
  output frame_t                push_frame,
  input  logic                  q_full
);

  localparam int unsigned IDX_W = $clog2(FRAME_BYTES);

  logic [FRAME_BYTES-1:0][7:0] store_r;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [7:0]                  prev_r;

  logic       accept;
  logic       wrap;
  logic       frame_end;
  logic       clear;
  logic [7:0] rx_byte;
  logic [7:0] byte0;

  assign rx_byte   = in_tdata[7:0];
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign wrap = (idx_r == IDX_W'(FRAME_BYTES - 1));
  // prev_r holds the byte at idx_r-1 whenever idx_r is nonzero
  assign frame_end = (idx_r != '0) && !wrap && (rx_byte == CH_LF) && (prev_r == CH_CR);
  assign byte0     = (idx_r == '0) ? rx_byte : store_r[0];
  assign clear     = frame_end || (byte0 != CH_A);

  always_comb begin
    if (clear) begin
      idx_nxt = '0;
    end else if (wrap) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  // bytes past the fill index are never matched, so clearing only resets the index
  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[idx_r] <= rx_byte;
      prev_r         <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (accept) begin
      idx_r <= idx_nxt;
    end
  end

  // snapshot of the store including the byte written this cycle
  genvar k;
  generate
    for (k = 0; k < SNAP_BYTES; k++) begin : g_snap
      assign push_frame.bytes[k] = (idx_r == IDX_W'(k)) ? rx_byte : store_r[k];
    end
  endgenerate

  assign push_frame.len = LEN_W'(idx_r) + LEN_W'(1);
  assign push           = accept && frame_end;

  a_end_clears_index: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (idx_r == '0))
    else $error("fill index not cleared after frame end");

endmodule

// File: design/scfd_queue.sv
// short frame queue between the assembler and the matcher
module scfd_queue
  import scfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_frame,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output frame_t head_frame
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  frame_t             entry_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_frame = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("frame queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(Q_DEPTH))
    else $error("frame queue count out of range");

endmodule

// File: design/scfd_cmd_match.sv
// back end: command table match and registered result
module scfd_cmd_match
  import scfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  frame_t                 head_frame,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [LEN_W-1:0] L4  = LEN_W'(4);
  localparam logic [LEN_W-1:0] L5  = LEN_W'(5);
  localparam logic [LEN_W-1:0] L6  = LEN_W'(6);
  localparam logic [LEN_W-1:0] L7  = LEN_W'(7);
  localparam logic [LEN_W-1:0] L8  = LEN_W'(8);
  localparam logic [LEN_W-1:0] L10 = LEN_W'(10);
  localparam logic [LEN_W-1:0] L11 = LEN_W'(11);
  localparam logic [LEN_W-1:0] L14 = LEN_W'(14);

  logic                       valid_r;
  cmd_t                       command_r, command_nxt;
  logic [PAY_W-1:0]           payload_r, payload_nxt;
  logic [LEN_W-1:0]           len;
  logic [SNAP_BYTES-1:0][7:0] b;
  logic [15:0]                p2;
  logic [23:0]                p3;
  logic [31:0]                p4;
  logic [31:0]                pay_lo;
  logic [31:0]                pay_hi;

  assign len = head_frame.len;
  assign b   = head_frame.bytes;
  // leading bytes with byte 0 in the top position, to compare against string literals
  assign p2  = {b[0], b[1]};
  assign p3  = {b[0], b[1], b[2]};
  assign p4  = {b[0], b[1], b[2], b[3]};
  // little-endian payload windows
  assign pay_lo = {b[5], b[4], b[3], b[2]};
  assign pay_hi = {b[7], b[6], b[5], b[4]};

  always_comb begin
    command_nxt = CMD_UNKNOWN;
    payload_nxt = '0;
    priority if (len == L4 && p4 == {"AT", CH_CR, CH_LF}) begin
      command_nxt = CMD_AT;
    end else if (len == L6 && {p4, b[4], b[5]} == {"AT+R", CH_CR, CH_LF}) begin
      command_nxt = CMD_AT_R;
    end else if (len == L4 && p4 == {"AS", CH_CR, CH_LF}) begin
      command_nxt = CMD_AS;
    end else if (len == L4 && p4 == {"AB", CH_CR, CH_LF}) begin
      command_nxt = CMD_AB;
    end else if (len == L4 && p4 == {"AR", CH_CR, CH_LF}) begin
      command_nxt = CMD_AR;
    end else if (len == L4 && p4 == {"AQ", CH_CR, CH_LF}) begin
      command_nxt = CMD_AQ;
    end else if (len == L8 && p2 == "AX") begin
      command_nxt = CMD_AX;
      payload_nxt = pay_lo;
    end else if (len == L8 && p2 == "AY") begin
      command_nxt = CMD_AY;
      payload_nxt = pay_lo;
    end else if (len == L8 && p2 == "AA") begin
      command_nxt = CMD_AA;
      payload_nxt = pay_lo;
    end else if (len == L14 && {p4, b[4], b[5], b[6], b[7], b[8], b[9], b[10], b[11],
                                b[12], b[13]} == {"AT+printData", CH_CR, CH_LF}) begin
      command_nxt = CMD_PRINT;
      payload_nxt = pay_hi;
    end else if (len == L11 && {p4, b[4], b[5], b[6], b[7], b[8], b[9], b[10]} ==
                 {"AT+noheat", CH_CR, CH_LF}) begin
      command_nxt = CMD_NOHEAT;
    end else if (len == L7 && {p4, b[4], b[5], b[6]} == {"AT+hf", CH_CR, CH_LF}) begin
      command_nxt = CMD_HF;
    end else if (len == L5 && p3 == "AME") begin
      command_nxt = CMD_AME;
    end else if (len == L5 && p3 == "AMC") begin
      command_nxt = CMD_AMC;
    end else if (len == L10 && p4 == "AWR1") begin
      command_nxt = CMD_AWR1;
      payload_nxt = pay_hi;
    end else if (len == L10 && p4 == "AWR2") begin
      command_nxt = CMD_AWR2;
      payload_nxt = pay_hi;
    end else if (len == L10 && p4 == "AAGE") begin
      command_nxt = CMD_AAGE;
      payload_nxt = pay_hi;
    end else if (len == L10 && p4 == "ACAF") begin
      command_nxt = CMD_ACAF;
      payload_nxt = pay_hi;
    end else if (len == L10 && p4 == "AGYS") begin
      command_nxt = CMD_AGYS;
      payload_nxt = pay_hi;
    end else begin
      command_nxt = CMD_UNKNOWN;
      payload_nxt = '0;
    end
  end

  // take the next frame when the output register is empty or being drained
  assign pop = head_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      command_r <= command_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_TDATA_W - CMD_W - PAY_W)'(0), payload_r, command_r};

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (command_r <= CMD_AGYS))
    else $error("command code out of range");

endmodule
